@@ rtl/ddlp_pkg.sv @@
// Shared constants, types and helpers for the differential-drive local pose update.
// No dependencies; used by the CORDIC cell, the top level and the checker.
package ddlp_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int DIV_STEPS         = 32;
    localparam int LAT_BASE          = 76;

    localparam int CW = 34;   // CORDIC vector width, Q2.30 with headroom
    localparam int ZW = 33;   // CORDIC angle width, Q4.28 with headroom

    localparam logic [30:0] WHEEL_BASE_RESET = 31'd65536;
    localparam logic [31:0] SMALL_ANGLE_Q28  = 32'd2684;
    localparam logic [31:0] HALF_PI_Q28      = 32'd421657428;
    localparam logic [32:0] PI_Q28           = 33'd843314857;
    localparam logic [33:0] GAIN_Q30         = 34'd652032874;
    localparam logic [31:0] RATIO_MAX        = 32'h8000_0000;

    typedef logic [41:0] mag_t;

    // Arctangent of 2^-i in Q4.28
    function automatic logic [29:0] atan_q28(input int i);
        logic [29:0] r;
        begin
            case (i)
                0: r = 30'd210828714;
                1: r = 30'd124459457;
                2: r = 30'd65760959;
                3: r = 30'd33381290;
                4: r = 30'd16755422;
                5: r = 30'd8385879;
                6: r = 30'd4193963;
                7: r = 30'd2097109;
                8: r = 30'd1048571;
                9: r = 30'd524287;
                default: r = (i <= 28) ? (30'd1 << (28 - i)) : 30'd0;
            endcase
            atan_q28 = r;
        end
    endfunction

    // Sign-magnitude to saturated two's complement
    function automatic logic [31:0] pack(input logic neg, input mag_t mag);
        logic [31:0] m;
        begin
            if (neg) begin
                m = (mag > 42'h0_8000_0000) ? 32'h8000_0000 : mag[31:0];
                pack = ~m + 32'd1;
            end
            else begin
                pack = (mag > 42'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            end
        end
    endfunction

endpackage

@@ rtl/ddlp_delay.sv @@
// Fixed-depth shift line for payload that rides alongside the cell chains.
// Depends on nothing.
module ddlp_delay #(
    parameter int W = 8,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [D];

    // Advance every tap each cycle
    always_ff @(posedge clk)
    begin
        tap_reg[0] <= din;
        for (int k = 1; k < D; k++)
        begin
            tap_reg[k] <= tap_reg[k-1];
        end
    end

    assign dout = tap_reg[D-1];

endmodule

@@ rtl/ddlp_div_cell.sv @@
// One restoring-division step: shifts one dividend bit into the partial
// remainder and one quotient bit out. Depends on nothing.
module ddlp_div_cell #(
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic [DW-1:0] rem_in,
    input  logic [31:0]   qd_in,
    input  logic [DW-1:0] d_in,
    output logic [DW-1:0] rem_out,
    output logic [31:0]   qd_out,
    output logic [DW-1:0] d_out
);

    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic [31:0]   qd_next;

    // Compare shifted remainder with the divisor
    always_comb
    begin
        trial    = {rem_in, qd_in[31]};
        ge       = trial >= {1'b0, d_in};
        rem_next = ge ? DW'(trial - {1'b0, d_in}) : trial[DW-1:0];
        qd_next  = {qd_in[30:0], ge};
    end

    always_ff @(posedge clk)
    begin
        rem_out <= rem_next;
        qd_out  <= qd_next;
        d_out   <= d_in;
    end

endmodule

@@ rtl/ddlp_cordic_cell.sv @@
// One rotation-mode CORDIC micro-rotation with a fixed shift.
// Depends on ddlp_pkg.
module ddlp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                          clk,
    input  logic signed [ddlp_pkg::CW-1:0] x_in,
    input  logic signed [ddlp_pkg::CW-1:0] y_in,
    input  logic signed [ddlp_pkg::ZW-1:0] z_in,
    output logic signed [ddlp_pkg::CW-1:0] x_out,
    output logic signed [ddlp_pkg::CW-1:0] y_out,
    output logic signed [ddlp_pkg::ZW-1:0] z_out
);

    localparam logic signed [ddlp_pkg::ZW-1:0] ATAN =
        ddlp_pkg::ZW'(ddlp_pkg::atan_q28(STAGE));

    logic signed [ddlp_pkg::CW-1:0] xs;
    logic signed [ddlp_pkg::CW-1:0] ys;

    assign xs = x_in >>> STAGE;
    assign ys = y_in >>> STAGE;

    // Rotate toward zero residual angle
    always_ff @(posedge clk)
    begin
        if (!z_in[ddlp_pkg::ZW-1])
        begin
            x_out <= x_in - ys;
            y_out <= y_in + xs;
            z_out <= z_in - ATAN;
        end
        else
        begin
            x_out <= x_in + ys;
            y_out <= y_in - xs;
            z_out <= z_in + ATAN;
        end
    end

endmodule

@@ rtl/diff_drive_local_pose_update.sv @@
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Results appear for one cycle under done and cannot be held off by the receiver.
// Reset clears the valid pipeline and sets wheel_base to 1.0 m; payload is unreset.
// Top level of the differential-drive local pose update; depends on ddlp_pkg,
// ddlp_delay, ddlp_div_cell and ddlp_cordic_cell.
module diff_drive_local_pose_update #(
    parameter int CORDIC_STAGES = ddlp_pkg::CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] left_velocity,
    input  logic [31:0] right_velocity,
    input  logic [31:0] time_step,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data,
    output logic        done,
    output logic [31:0] delta_forward,
    output logic [31:0] delta_lateral,
    output logic [31:0] delta_heading
);

    localparam int N   = CORDIC_STAGES;
    localparam int NS  = ddlp_pkg::DIV_STEPS;
    localparam int LAT = ddlp_pkg::LAT_BASE + N;
    localparam int CW  = ddlp_pkg::CW;
    localparam int ZW  = ddlp_pkg::ZW;

    // Configuration register
    logic [30:0] wb_reg;
    logic [30:0] wb_eff;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign wb_eff    = (wb_reg == 31'd0) ? 31'd1 : wb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_reg <= ddlp_pkg::WHEEL_BASE_RESET;
        else if (cfg_valid && cfg_ready)
            wb_reg <= cfg_data;
    end

    // Valid shift line
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign vld_next = {vld_reg[LAT-2:0], start && !busy};
    assign done     = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Stage 1: sum and difference magnitudes
    logic signed [32:0] sum_w;
    logic signed [32:0] dif_w;
    logic [32:0] smag1_reg, dmag1_reg;
    logic [31:0] dt1_reg;
    logic        fneg1_reg, tneg1_reg;

    assign sum_w = {left_velocity[31], left_velocity} + {right_velocity[31], right_velocity};
    assign dif_w = {right_velocity[31], right_velocity} - {left_velocity[31], left_velocity};

    always_ff @(posedge clk)
    begin
        smag1_reg <= sum_w[32] ? 33'(~sum_w + 33'sd1) : sum_w;
        dmag1_reg <= dif_w[32] ? 33'(~dif_w + 33'sd1) : dif_w;
        dt1_reg   <= time_step;
        fneg1_reg <= sum_w[32];
        tneg1_reg <= dif_w[32];
    end

    // Stage 2: scale by the time step
    logic [63:0] fprod_w, pprod_w;
    logic [38:0] fmag2_reg;
    logic [63:0] p2_reg;
    logic        fneg2_reg, tneg2_reg;

    assign fprod_w = smag1_reg[32] ? {dt1_reg, 32'd0} : smag1_reg[31:0] * dt1_reg;
    assign pprod_w = dmag1_reg[32] ? {dt1_reg, 32'd0} : dmag1_reg[31:0] * dt1_reg;

    always_ff @(posedge clk)
    begin
        fmag2_reg <= fprod_w[63:25];
        p2_reg    <= pprod_w;
        fneg2_reg <= fneg1_reg;
        tneg2_reg <= tneg1_reg;
    end

    // Stage 3: set up heading division by wheel base
    logic [30:0] rem3_reg;
    logic [31:0] qd3_reg;
    logic [30:0] d3_reg;
    logic        ovf3_reg;
    logic [38:0] fmag3_reg;
    logic        fneg3_reg, tneg3_reg;

    always_ff @(posedge clk)
    begin
        ovf3_reg  <= p2_reg[63:28] >= {5'd0, wb_eff};
        rem3_reg  <= p2_reg[58:28];
        qd3_reg   <= {p2_reg[27:0], 4'd0};
        d3_reg    <= wb_eff;
        fmag3_reg <= fmag2_reg;
        fneg3_reg <= fneg2_reg;
        tneg3_reg <= tneg2_reg;
    end

    // Heading divider chain
    logic [30:0] h_rem [NS+1];
    logic [31:0] h_qd  [NS+1];
    logic [30:0] h_d   [NS+1];

    assign h_rem[0] = rem3_reg;
    assign h_qd[0]  = qd3_reg;
    assign h_d[0]   = d3_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_hdiv
        ddlp_div_cell #(.DW(31)) u_cell (
            .clk     (clk),
            .rem_in  (h_rem[k]),
            .qd_in   (h_qd[k]),
            .d_in    (h_d[k]),
            .rem_out (h_rem[k+1]),
            .qd_out  (h_qd[k+1]),
            .d_out   (h_d[k+1])
        );
    end

    logic [38:0] fmag35;
    logic        fneg35, tneg35, ovf35;

    ddlp_delay #(.W(42), .D(NS)) u_dly_hdiv (
        .clk  (clk),
        .din  ({fmag3_reg, fneg3_reg, tneg3_reg, ovf3_reg}),
        .dout ({fmag35, fneg35, tneg35, ovf35})
    );

    // Stage 36: saturate the heading
    logic [31:0] araw_w, aclamp_w;
    logic [31:0] a36_reg;
    logic [38:0] fmag36_reg;
    logic        fneg36_reg, tneg36_reg;

    always_comb
    begin
        araw_w = ovf35 ? 32'hFFFF_FFFF : h_qd[NS];
        if (tneg35)
            aclamp_w = (araw_w > 32'h8000_0000) ? 32'h8000_0000 : araw_w;
        else
            aclamp_w = (araw_w > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : araw_w;
    end

    always_ff @(posedge clk)
    begin
        a36_reg    <= aclamp_w;
        fmag36_reg <= fmag35;
        fneg36_reg <= fneg35;
        tneg36_reg <= tneg35;
    end

    // Stage 37: half angle folded into CORDIC range; small-angle terms start
    logic [31:0]          half_w;
    logic signed [ZW-1:0] z37_reg;
    logic                 small37_reg;
    logic [23:0]          asq37_reg;
    logic [50:0]          fa37_reg;
    logic [38:0]          fmag37_reg;

    assign half_w = {1'b0, a36_reg[31:1]};

    always_ff @(posedge clk)
    begin
        if (half_w > ddlp_pkg::HALF_PI_Q28)
            z37_reg <= $signed({1'b0, half_w}) - $signed(ddlp_pkg::PI_Q28);
        else
            z37_reg <= $signed({1'b0, half_w});
        small37_reg <= a36_reg <= ddlp_pkg::SMALL_ANGLE_Q28;
        asq37_reg   <= a36_reg[11:0] * a36_reg[11:0];
        fa37_reg    <= fmag36_reg * a36_reg[11:0];
        fmag37_reg  <= fmag36_reg;
    end

    // Small-angle Taylor branch
    logic [42:0] hi38_reg;
    logic [43:0] lo38_reg;
    logic [21:0] dyms38_reg, dyms39_reg;
    logic [38:0] fmag38_reg, dxms39_reg;
    logic        small38_reg, small39_reg;
    logic [63:0] corr_sum_w;
    logic [11:0] corr_mul_w;

    assign corr_sum_w = {1'b0, hi38_reg, 20'd0} + {20'd0, lo38_reg};
    assign corr_mul_w = corr_sum_w[61:56] * 6'd43;

    always_ff @(posedge clk)
    begin
        hi38_reg    <= fmag37_reg[38:20] * asq37_reg;
        lo38_reg    <= fmag37_reg[19:0] * asq37_reg;
        dyms38_reg  <= fa37_reg[50:29];
        fmag38_reg  <= fmag37_reg;
        small38_reg <= small37_reg;
        dxms39_reg  <= fmag38_reg - {35'd0, corr_mul_w[11:8]};
        dyms39_reg  <= dyms38_reg;
        small39_reg <= small38_reg;
    end

    logic [38:0] dxms_e;
    logic [21:0] dyms_e;
    logic        small_e;

    ddlp_delay #(.W(62), .D(36 + N)) u_dly_small (
        .clk  (clk),
        .din  ({small39_reg, dxms39_reg, dyms39_reg}),
        .dout ({small_e, dxms_e, dyms_e})
    );

    // CORDIC chain on the half angle
    logic signed [CW-1:0] cx [N+1];
    logic signed [CW-1:0] cy [N+1];
    logic signed [ZW-1:0] cz [N+1];

    assign cx[0] = $signed(ddlp_pkg::GAIN_Q30);
    assign cy[0] = '0;
    assign cz[0] = z37_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_cordic
        ddlp_cordic_cell #(.STAGE(k)) u_cell (
            .clk   (clk),
            .x_in  (cx[k]),
            .y_in  (cy[k]),
            .z_in  (cz[k]),
            .x_out (cx[k+1]),
            .y_out (cy[k+1]),
            .z_out (cz[k+1])
        );
    end

    // Double-angle products
    logic signed [31:0] s32_w, c32_w;
    logic signed [63:0] sc_reg, ss_reg;
    logic signed [63:0] sa_w;
    logic [32:0]        sam_reg, omc_reg;
    logic               flip_reg;

    assign s32_w = cy[N][31:0];
    assign c32_w = cx[N][31:0];
    assign sa_w  = sc_reg >>> 29;

    always_ff @(posedge clk)
    begin
        sc_reg   <= s32_w * c32_w;
        ss_reg   <= s32_w * s32_w;
        sam_reg  <= sa_w[63] ? 33'(-sa_w) : sa_w[32:0];
        omc_reg  <= ss_reg[61:29];
        flip_reg <= sa_w[63];
    end

    logic [31:0] a_div;

    ddlp_delay #(.W(32), .D(3 + N)) u_dly_adiv (
        .clk  (clk),
        .din  (a36_reg),
        .dout (a_div)
    );

    // Set up ratio divisions by the heading
    logic [31:0] r1rem_reg, r2rem_reg, r1qd_reg, r2qd_reg, rd_reg;
    logic        r1ovf_reg, r2ovf_reg;

    always_ff @(posedge clk)
    begin
        r1ovf_reg <= {3'd0, sam_reg[32:4]} >= a_div;
        r2ovf_reg <= {3'd0, omc_reg[32:4]} >= a_div;
        r1rem_reg <= {3'd0, sam_reg[32:4]};
        r2rem_reg <= {3'd0, omc_reg[32:4]};
        r1qd_reg  <= {sam_reg[3:0], 28'd0};
        r2qd_reg  <= {omc_reg[3:0], 28'd0};
        rd_reg    <= a_div;
    end

    // Ratio divider chains
    logic [31:0] r1_rem [NS+1];
    logic [31:0] r1_qd  [NS+1];
    logic [31:0] r1_d   [NS+1];
    logic [31:0] r2_rem [NS+1];
    logic [31:0] r2_qd  [NS+1];
    logic [31:0] r2_d   [NS+1];

    assign r1_rem[0] = r1rem_reg;
    assign r1_qd[0]  = r1qd_reg;
    assign r1_d[0]   = rd_reg;
    assign r2_rem[0] = r2rem_reg;
    assign r2_qd[0]  = r2qd_reg;
    assign r2_d[0]   = rd_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_rdiv
        ddlp_div_cell #(.DW(32)) u_cell1 (
            .clk     (clk),
            .rem_in  (r1_rem[k]),
            .qd_in   (r1_qd[k]),
            .d_in    (r1_d[k]),
            .rem_out (r1_rem[k+1]),
            .qd_out  (r1_qd[k+1]),
            .d_out   (r1_d[k+1])
        );
        ddlp_div_cell #(.DW(32)) u_cell2 (
            .clk     (clk),
            .rem_in  (r2_rem[k]),
            .qd_in   (r2_qd[k]),
            .d_in    (r2_d[k]),
            .rem_out (r2_rem[k+1]),
            .qd_out  (r2_qd[k+1]),
            .d_out   (r2_d[k+1])
        );
    end

    logic r1ovf_e, r2ovf_e, flip_e;

    ddlp_delay #(.W(2), .D(NS)) u_dly_rovf (
        .clk  (clk),
        .din  ({r1ovf_reg, r2ovf_reg}),
        .dout ({r1ovf_e, r2ovf_e})
    );

    ddlp_delay #(.W(1), .D(36)) u_dly_flip (
        .clk  (clk),
        .din  (flip_reg),
        .dout (flip_e)
    );

    logic [31:0] a73;
    logic [38:0] fmag73;
    logic        fneg73, tneg73;

    ddlp_delay #(.W(73), .D(37 + N)) u_dly_main (
        .clk  (clk),
        .din  ({a36_reg, fmag36_reg, fneg36_reg, tneg36_reg}),
        .dout ({a73, fmag73, fneg73, tneg73})
    );

    // Clamp ratios
    logic [31:0] r1_reg, r2_reg;
    logic [31:0] a74_reg, a75_reg;
    logic        fneg74_reg, tneg74_reg, fneg75_reg, tneg75_reg;

    always_ff @(posedge clk)
    begin
        r1_reg     <= (r1ovf_e || r1_qd[NS] > ddlp_pkg::RATIO_MAX) ?
                      ddlp_pkg::RATIO_MAX : r1_qd[NS];
        r2_reg     <= (r2ovf_e || r2_qd[NS] > ddlp_pkg::RATIO_MAX) ?
                      ddlp_pkg::RATIO_MAX : r2_qd[NS];
        a74_reg    <= a73;
        fneg74_reg <= fneg73;
        tneg74_reg <= tneg73;
    end

    // Scale forward distance by the ratios
    logic [50:0] hi1_reg, hi2_reg;
    logic [51:0] lo1_reg, lo2_reg;
    logic [51:0] sum1_w, sum2_w;
    logic [41:0] dxml_reg, dyml_reg;

    assign sum1_w = {1'b0, hi1_reg} + {20'd0, lo1_reg[51:20]};
    assign sum2_w = {1'b0, hi2_reg} + {20'd0, lo2_reg[51:20]};

    always_ff @(posedge clk)
    begin
        hi1_reg    <= fmag73[38:20] * r1_reg;
        lo1_reg    <= fmag73[19:0] * r1_reg;
        hi2_reg    <= fmag73[38:20] * r2_reg;
        lo2_reg    <= fmag73[19:0] * r2_reg;
        a75_reg    <= a74_reg;
        fneg75_reg <= fneg74_reg;
        tneg75_reg <= tneg74_reg;
        dxml_reg   <= sum1_w[51:10];
        dyml_reg   <= sum2_w[51:10];
    end

    // Select branch and saturate outputs
    ddlp_pkg::mag_t dxm_w, dym_w;
    logic           dxneg_w, dyneg_w;

    always_comb
    begin
        dxm_w   = small_e ? {3'd0, dxms_e} : dxml_reg;
        dym_w   = small_e ? {20'd0, dyms_e} : dyml_reg;
        dxneg_w = small_e ? fneg75_reg : (fneg75_reg ^ flip_e);
        dyneg_w = fneg75_reg ^ tneg75_reg;
    end

    always_ff @(posedge clk)
    begin
        delta_forward <= ddlp_pkg::pack((dxm_w != '0) && dxneg_w, dxm_w);
        delta_lateral <= ddlp_pkg::pack((dym_w != '0) && dyneg_w, dym_w);
        delta_heading <= ddlp_pkg::pack((a75_reg != 32'd0) && tneg75_reg,
                                        {10'd0, a75_reg});
    end

endmodule

@@ rtl/ddlp_checker.sv @@
// Port-level checker for the pose update block, bound to the top level.
// Depends on ddlp_pkg.
module ddlp_checker #(
    parameter int CORDIC_STAGES = ddlp_pkg::CORDIC_STAGES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [31:0] left_velocity,
    input logic [31:0] right_velocity,
    input logic [31:0] time_step,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [30:0] cfg_data,
    input logic        done,
    input logic [31:0] delta_forward,
    input logic [31:0] delta_lateral,
    input logic [31:0] delta_heading
);

    localparam int LAT = ddlp_pkg::LAT_BASE + CORDIC_STAGES;

    // Every result traces back to one accepted transaction
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching transaction");

    // Every accepted transaction yields a result
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transaction produced no result");

    // Zero time step moves nothing
    a_zero_dt: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && time_step == 32'd0) |-> ##LAT
        (delta_forward == 32'd0 && delta_lateral == 32'd0 && delta_heading == 32'd0))
        else $error("nonzero pose change for zero time step");

    // Equal wheel speeds give no turn and no lateral drift
    a_straight: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && left_velocity == right_velocity) |-> ##LAT
        (delta_heading == 32'd0 && delta_lateral == 32'd0))
        else $error("straight motion produced a turn");

endmodule

bind diff_drive_local_pose_update ddlp_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_ddlp_checker (.*);
